[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks for the RTL modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is low.
`define ICC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Checked on every rising edge, including during reset.
`define ICC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

[hw/rtl/icc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval coverage classifier package
// Shared types and constants for the classifier and its storage.
// ----------------------------------------------------------------------------
package icc_pkg;

  localparam int BOUND_W = 32;
  localparam int RUN_W   = BOUND_W + 1;
  localparam int ENTRY_W = 2 * BOUND_W;
  localparam int HELD_W  = 8;

  typedef enum logic [1:0] {
    ST_COVERED  = 2'd0,
    ST_DISJOINT = 2'd1,
    ST_PARTIAL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_WALK = 1'b1
  } state_t;

endpackage

[hw/rtl/icc_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module icc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/interval_coverage_classifier.sv]
`timescale 1ns / 1ps
// An empty store answers a query straight from the idle state and stores it;
// otherwise the query walks the stored entries in order (at most the number
// held), stopping once it is covered. The walk compares one stored entry per
// cycle, bound by the single read port of the interval memory; busy is high
// until done. Reset clears the entry count, the state and the done strobe;
// memory stays undefined, and only entries already written are compared.
// ----------------------------------------------------------------------------
// Interval coverage classifier
// Walks the stored intervals in insertion order to classify a query interval
// as covered, disjoint or partial, and appends disjoint ones while not full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module interval_coverage_classifier #(
  parameter int MAX_ENTRIES = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] lower_bound,
  input  logic signed [31:0] upper_bound,
  output logic               done,
  output logic [1:0]         status,
  output logic               was_stored,
  output logic [7:0]         entries_held
);

  import icc_pkg::*;

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  state_t                    state, state_next;
  logic [AW-1:0]             idx, idx_next;
  logic [CW-1:0]             count, count_next;
  logic signed [RUN_W-1:0]   run_lo, run_lo_next;
  logic signed [RUN_W-1:0]   run_hi, run_hi_next;
  logic signed [BOUND_W-1:0] lb, lb_next;
  logic signed [BOUND_W-1:0] ub, ub_next;
  logic                      done_next;
  status_t                   status_r, status_next;
  logic                      stored_next;
  logic [HELD_W-1:0]         held_next;

  logic                      we;
  logic [AW-1:0]             waddr;
  logic [ENTRY_W-1:0]        wdata;
  logic [AW-1:0]             raddr;
  logic [ENTRY_W-1:0]        rdata;

  logic signed [RUN_W-1:0]   lo_e, hi_e, nlo, nhi;
  logic [CW-1:0]             idx_plus;
  logic                      crossed, last, unchanged, room;

  icc_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    lo_e      = $signed({rdata[ENTRY_W-1], rdata[ENTRY_W-1:BOUND_W]});
    hi_e      = $signed({rdata[BOUND_W-1], rdata[BOUND_W-1:0]});
    nlo       = (lo_e <= run_lo && hi_e >= run_lo) ? hi_e + RUN_W'(1) : run_lo;
    nhi       = (lo_e <= run_hi && hi_e >= run_hi) ? lo_e - RUN_W'(1) : run_hi;
    crossed   = nlo > nhi;
    idx_plus  = CW'(idx) + CW'(1);
    last      = crossed || (idx_plus == count);
    unchanged = (nlo == RUN_W'(lb)) && (nhi == RUN_W'(ub));
    room      = count < CW'(MAX_ENTRIES);

    state_next  = state;
    idx_next    = idx;
    count_next  = count;
    run_lo_next = run_lo;
    run_hi_next = run_hi;
    lb_next     = lb;
    ub_next     = ub;
    done_next   = 1'b0;
    status_next = status_r;
    stored_next = was_stored;
    held_next   = entries_held;
    we          = 1'b0;
    waddr       = AW'(count);
    wdata       = {lb, ub};
    raddr       = '0;

    case (state)
      S_IDLE: begin
        if (start) begin
          lb_next     = lower_bound;
          ub_next     = upper_bound;
          run_lo_next = RUN_W'(lower_bound);
          run_hi_next = RUN_W'(upper_bound);
          idx_next    = '0;
          if (count == '0) begin
            we          = 1'b1;
            wdata       = {lower_bound, upper_bound};
            count_next  = CW'(1);
            done_next   = 1'b1;
            status_next = ST_DISJOINT;
            stored_next = 1'b1;
            held_next   = HELD_W'(CW'(1));
          end else begin
            state_next = S_WALK;
          end
        end
      end
      S_WALK: begin
        raddr       = AW'(idx_plus);
        run_lo_next = nlo;
        run_hi_next = nhi;
        idx_next    = AW'(idx_plus);
        if (last) begin
          state_next  = S_IDLE;
          done_next   = 1'b1;
          stored_next = 1'b0;
          if (crossed) begin
            status_next = ST_COVERED;
          end else if (unchanged) begin
            status_next = ST_DISJOINT;
            if (room) begin
              we          = 1'b1;
              count_next  = count + CW'(1);
              stored_next = 1'b1;
            end
          end else begin
            status_next = ST_PARTIAL;
          end
          held_next = HELD_W'(count_next);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
    idx          <= idx_next;
    run_lo       <= run_lo_next;
    run_hi       <= run_hi_next;
    lb           <= lb_next;
    ub           <= ub_next;
    status_r     <= status_next;
    was_stored   <= stored_next;
    entries_held <= held_next;
  end

  assign busy   = (state != S_IDLE);
  assign status = status_r;

  `ICC_ASSERT(a_count_bounded, clk, rst, count <= CW'(MAX_ENTRIES))
  `ICC_ASSERT(a_stored_is_disjoint, clk, rst, (done && was_stored) |-> (status_r == ST_DISJOINT))
  `ICC_ASSERT(a_accept_progress, clk, rst, (start && !busy) |=> (busy || done))
  `ICC_ASSERT(a_single_strobe, clk, rst, done |=> !done)
  `ICC_ASSERT(a_count_grows_on_store, clk, rst, (done && was_stored) |-> (count != $past(count)))

endmodule

[tb/sv/tb_interval_coverage_classifier.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval coverage classifier testbench
// Sends query intervals through the start/busy handshake and predicts each
// result with a cycle-free model of the interval store. Directed queries hit
// the bound extremes, inverted intervals and chained coverage. Random queries
// then fill the store up to its capacity and probe the stored intervals.
// ----------------------------------------------------------------------------
module tb_interval_coverage_classifier;
  import icc_pkg::*;

  localparam int STORE_DEPTH   = 128;
  localparam int RANDOM_ITEMS  = 800;
  localparam int QUIET_TAIL    = 100;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam logic signed [BOUND_W-1:0] BMIN = 32'sh8000_0000;
  localparam logic signed [BOUND_W-1:0] BMAX = 32'sh7fff_ffff;

  typedef struct {
    status_t    status;
    logic       stored;
    logic [7:0] held;
  } coverage_result_t;

  class coverage_scoreboard;
    logic signed [BOUND_W-1:0] lows [STORE_DEPTH];
    logic signed [BOUND_W-1:0] highs [STORE_DEPTH];
    int unsigned held;
    coverage_result_t pending [$];
    int errors;
    int queries;
    int n_covered;
    int n_disjoint;
    int n_partial;
    int n_dropped;

    function void note_query(logic signed [BOUND_W-1:0] lb, logic signed [BOUND_W-1:0] ub);
      logic signed [RUN_W-1:0] run_lo;
      logic signed [RUN_W-1:0] run_hi;
      logic signed [RUN_W-1:0] lo_w;
      logic signed [RUN_W-1:0] hi_w;
      coverage_result_t r;
      int i;
      run_lo = lb;
      run_hi = ub;
      r.stored = 1'b0;
      queries++;
      if (held != 0) begin
        for (i = 0; i < held; i++) begin
          lo_w = lows[i];
          hi_w = highs[i];
          if (lo_w <= run_lo && hi_w >= run_lo) run_lo = hi_w + 1;
          if (lo_w <= run_hi && hi_w >= run_hi) run_hi = lo_w - 1;
          if (run_lo > run_hi) break;
        end
      end
      if (held != 0 && run_lo > run_hi) begin
        r.status = ST_COVERED;
        n_covered++;
      end else if (held == 0 || (run_lo == lb && run_hi == ub)) begin
        r.status = ST_DISJOINT;
        n_disjoint++;
        if (held < STORE_DEPTH) begin
          lows[held] = lb;
          highs[held] = ub;
          held++;
          r.stored = 1'b1;
        end else begin
          n_dropped++;
        end
      end else begin
        r.status = ST_PARTIAL;
        n_partial++;
      end
      r.held = 8'(held);
      pending.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic ws, logic [7:0] eh);
      coverage_result_t r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word, status %0d stored %0d held %0d",
                 $time, st, ws, eh);
        errors++;
      end else begin
        r = pending.pop_front();
        if (st !== r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, r.status, st);
          errors++;
        end
        if (ws !== r.stored) begin
          $display("%0t: was_stored expected %0d actual %0d", $time, r.stored, ws);
          errors++;
        end
        if (eh !== r.held) begin
          $display("%0t: entries_held expected %0d actual %0d", $time, r.held, eh);
          errors++;
        end
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic signed [BOUND_W-1:0] lower_bound;
  logic signed [BOUND_W-1:0] upper_bound;
  logic                      done;
  logic [1:0]                status;
  logic                      was_stored;
  logic [7:0]                entries_held;

  coverage_scoreboard sb;
  int cycles = 0;

  interval_coverage_classifier #(
    .MAX_ENTRIES(STORE_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .lower_bound(lower_bound),
    .upper_bound(upper_bound),
    .done(done),
    .status(status),
    .was_stored(was_stored),
    .entries_held(entries_held)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_interval_coverage_classifier NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(status, was_stored, entries_held);
  end

  function automatic logic signed [BOUND_W-1:0] clamp_bound(longint v);
    if (v > longint'(BMAX)) return BMAX;
    if (v < longint'(BMIN)) return BMIN;
    return BOUND_W'(v);
  endfunction

  task automatic send_query(logic signed [BOUND_W-1:0] lb, logic signed [BOUND_W-1:0] ub,
                            bit may_idle);
    if (may_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start <= 1'b1;
    lower_bound <= lb;
    upper_bound <= ub;
    do @(posedge clk); while (busy);
    sb.note_query(lb, ub);
  endtask

  task automatic pick_query(output logic signed [BOUND_W-1:0] lb,
                            output logic signed [BOUND_W-1:0] ub);
    int kind;
    int i;
    int j;
    longint lo;
    longint hi;
    longint a;
    longint b;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      a = longint'($signed($urandom));
      lb = clamp_bound(a);
      ub = clamp_bound(a + $urandom_range(0, 15));
    end else if (kind < 60) begin
      a = $urandom_range(0, 4000);
      lb = clamp_bound(a);
      ub = clamp_bound(a + $urandom_range(0, 200));
    end else if (kind < 85) begin
      i = $urandom_range(0, sb.held - 1);
      j = $urandom_range(0, sb.held - 1);
      lo = longint'(sb.lows[i]);
      hi = longint'(sb.highs[i]);
      case ($urandom_range(0, 3))
        0: begin
          lb = clamp_bound(lo + $urandom_range(0, 3));
          ub = clamp_bound(hi - $urandom_range(0, 3));
        end
        1: begin
          lb = sb.lows[i];
          ub = sb.highs[j];
        end
        2: begin
          lb = clamp_bound(lo - $urandom_range(1, 50));
          ub = clamp_bound(lo + $urandom_range(0, 50));
        end
        default: begin
          lb = clamp_bound(hi - $urandom_range(0, 50));
          ub = clamp_bound(hi + $urandom_range(1, 50));
        end
      endcase
    end else if (kind < 93 || sb.held < STORE_DEPTH) begin
      a = longint'($signed($urandom));
      b = longint'($signed($urandom));
      lb = clamp_bound(a > b ? a : b);
      ub = clamp_bound(a > b ? b : a);
    end else begin
      a = longint'($signed($urandom));
      b = longint'($signed($urandom));
      lb = clamp_bound(a < b ? a : b);
      ub = clamp_bound(a < b ? b : a);
    end
  endtask

  initial begin
    logic signed [BOUND_W-1:0] lb;
    logic signed [BOUND_W-1:0] ub;
    int n;
    sb = new();
    rst <= 1'b1;
    start <= 1'b0;
    lower_bound <= '0;
    upper_bound <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // An inverted interval into the empty store is stored but holds nothing.
    send_query(BMAX, BMIN, 1'b1);
    send_query(BMIN, BMIN + 5, 1'b1);
    send_query(BMAX - 5, BMAX, 1'b1);
    send_query(BMIN, BMAX, 1'b1);
    send_query(BMAX, BMAX, 1'b1);
    send_query(BMIN, BMIN, 1'b1);
    send_query(100, 200, 1'b1);
    send_query(150, 180, 1'b1);
    send_query(50, 150, 1'b1);
    send_query(201, 300, 1'b1);
    send_query(100, 300, 1'b1);
    send_query(300, 100, 1'b1);
    send_query(0, 0, 1'b1);
    send_query(-1, -1, 1'b1);
    send_query(-1, 0, 1'b1);
    send_query(-10, 10, 1'b1);
    send_query(-5, 5, 1'b1);
    send_query(5, 20, 1'b1);
    send_query(32'sh5555_5555, 32'sh5555_5555, 1'b1);
    send_query(32'shaaaa_aaaa, 32'shaaaa_aaab, 1'b1);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      pick_query(lb, ub);
      send_query(lb, ub, n < RANDOM_ITEMS - QUIET_TAIL);
    end
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (2 * STORE_DEPTH + 8) @(posedge clk);

    $display("Ran %0d queries: %0d covered, %0d disjoint, %0d partial.",
             sb.queries, sb.n_covered, sb.n_disjoint, sb.n_partial);
    $display("Store reached %0d entries; %0d disjoint queries found it full.",
             sb.held, sb.n_dropped);
    if (sb.errors == 0) begin
      $display("tb_interval_coverage_classifier OK");
    end else begin
      $display("tb_interval_coverage_classifier NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/icc_pkg.sv
hw/rtl/icc_ram.sv
hw/rtl/interval_coverage_classifier.sv
tb/sv/tb_interval_coverage_classifier.sv
